### src/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and exp tables of the softmax forward/backward unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

  localparam int COL_W    = 7;
  localparam int IDX_W    = 6;
  localparam int RB_DEPTH = 64;
  localparam int DATA_W   = 16;
  localparam int SUM_W    = 32;
  localparam int ACC_W    = 40;
  localparam int EXP_W    = 17;
  localparam int DIV_STEPS = 16;

  localparam logic REQ_FWD = 1'b0;
  localparam logic REQ_BWD = 1'b1;

  localparam logic [COL_W-1:0] ROW_LEN_RST = 7'd64;

  typedef struct packed {
    logic             rb_we;
    logic [IDX_W-1:0] rb_waddr;
    logic             rd_en;
    logic [IDX_W-1:0] rb_raddr;
    logic             clr_acc;
    logic             max_upd;
    logic             max_first;
    logic             exp_start;
    logic             exp_mid;
    logic             exp_fin;
    logic             sum_acc;
    logic             div_load;
    logic             div_step;
    logic             bs_mul;
    logic             bs_acc;
    logic             bo_diff;
    logic             bo_mul;
    logic             bo_fin;
    logic             st_we;
    logic             emit;
    logic             emit_kind;
    logic             emit_last;
    logic             emit_ovf;
    logic             emit_zero;
    logic [IDX_W-1:0] row_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // exp(-i), i integer part
  function automatic logic [EXP_W-1:0] exp_int(input logic [7:0] i);
    logic [EXP_W-1:0] e;
    case (i)
      8'd0:    e = 17'd65536;
      8'd1:    e = 17'd24109;
      8'd2:    e = 17'd8869;
      8'd3:    e = 17'd3263;
      8'd4:    e = 17'd1200;
      8'd5:    e = 17'd442;
      8'd6:    e = 17'd162;
      8'd7:    e = 17'd60;
      8'd8:    e = 17'd22;
      8'd9:    e = 17'd8;
      8'd10:   e = 17'd3;
      8'd11:   e = 17'd1;
      default: e = 17'd0;
    endcase
    return e;
  endfunction

  // exp(-h/16)
  function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] h);
    logic [EXP_W-1:0] e;
    case (h)
      4'd0:    e = 17'd65536;
      4'd1:    e = 17'd61565;
      4'd2:    e = 17'd57835;
      4'd3:    e = 17'd54331;
      4'd4:    e = 17'd51039;
      4'd5:    e = 17'd47947;
      4'd6:    e = 17'd45042;
      4'd7:    e = 17'd42313;
      4'd8:    e = 17'd39750;
      4'd9:    e = 17'd37341;
      4'd10:   e = 17'd35079;
      4'd11:   e = 17'd32954;
      4'd12:   e = 17'd30957;
      4'd13:   e = 17'd29081;
      4'd14:   e = 17'd27319;
      default: e = 17'd25664;
    endcase
    return e;
  endfunction

  // exp(-l/256)
  function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] l);
    logic [EXP_W-1:0] e;
    case (l)
      4'd0:    e = 17'd65536;
      4'd1:    e = 17'd65280;
      4'd2:    e = 17'd65026;
      4'd3:    e = 17'd64772;
      4'd4:    e = 17'd64520;
      4'd5:    e = 17'd64268;
      4'd6:    e = 17'd64018;
      4'd7:    e = 17'd63768;
      4'd8:    e = 17'd63520;
      4'd9:    e = 17'd63272;
      4'd10:   e = 17'd63025;
      4'd11:   e = 17'd62781;
      4'd12:   e = 17'd62535;
      4'd13:   e = 17'd62291;
      4'd14:   e = 17'd62048;
      default: e = 17'd61806;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

### src/sfb_in_if.sv
// ----------------------------------------------------------------------------
// sfb_in_if
// Request channel: forward elements and backward error elements.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfb_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] value;
  logic        last_of_tensor;

  modport source (output valid, output req_type, output value, output last_of_tensor,
                  input ready);
  modport sink   (input valid, input req_type, input value, input last_of_tensor,
                  output ready);
endinterface

`default_nettype wire

### src/sfb_out_if.sv
// ----------------------------------------------------------------------------
// sfb_out_if
// Result channel: probabilities and gradients.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfb_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  row_index;
  logic [15:0] result;
  logic        last_in_row;
  logic        overflow;

  modport source (output valid, output kind, output row_index, output result,
                  output last_in_row, output overflow, input ready);
  modport sink   (input valid, input kind, input row_index, input result,
                  input last_in_row, input overflow, output ready);
endinterface

`default_nettype wire

### src/sfb_dp.sv
// ----------------------------------------------------------------------------
// sfb_dp
// Datapath: row buffer, output store, exp chain, serial divider, gradient
// arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_dp import sfb_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  localparam int StAddrW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  input  wire logic [StAddrW-1:0] st_addr_i,
  input  wire logic [DATA_W-1:0]  value_i,
  output      dp_sts_t            sts_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               out_kind_o,
  output      logic [IDX_W-1:0]   out_row_index_o,
  output      logic [DATA_W-1:0]  out_result_o,
  output      logic               out_last_o,
  output      logic               out_ovf_o
);

  localparam int StDepth = MAX_ROWS * MAX_COLS;

  logic [DATA_W-1:0] rb_mem [RB_DEPTH];
  logic [DATA_W-1:0] st_mem [StDepth];
  logic [DATA_W-1:0] rb_rd_q, st_rd_q;

  logic signed [DATA_W-1:0] max_q;
  logic [SUM_W-1:0]         sum_q;
  logic [3:0]               l_q;
  logic [2*EXP_W-1:0]       p1_q, p2_q;
  logic [EXP_W-1:0]         e_q;
  logic [SUM_W:0]           rem_q;
  logic [15:0]              num_lo_q;
  logic [15:0]              quo_q;
  logic signed [32:0]       bprod_q;
  logic signed [ACC_W-1:0]  s_q;
  logic signed [ACC_W-1:0]  d_q;
  logic [DATA_W-1:0]        y_q;
  logic signed [36:0]       hp_q;
  logic signed [37:0]       lp_q;
  logic [DATA_W-1:0]        grad_q;

  logic                     valid_q;
  logic                     kind_q, last_q, ovf_q;
  logic [IDX_W-1:0]         idx_q;
  logic [DATA_W-1:0]        res_q;

  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W:0]   tdiff;
  logic [15:0]              t;
  logic [EXP_W-1:0]         e1, e2;
  logic [SUM_W:0]           num;
  logic [SUM_W:0]           sh;
  logic signed [57:0]       r, w, gr;
  logic [DATA_W-1:0]        p_sat;
  logic signed [ACC_W-1:0]  d_next;

  assign x     = $signed(rb_rd_q);
  assign tdiff = {max_q[DATA_W-1], max_q} - {x[DATA_W-1], x};
  assign t     = tdiff[15:0];
  assign e1    = EXP_W'((35'(p1_q) + 35'd32768) >> 16);
  assign e2    = EXP_W'((35'(p2_q) + 35'd32768) >> 16);
  assign num   = {1'b0, e_q, 15'd0} + (SUM_W + 1)'(sum_q >> 1);
  assign sh    = {rem_q[SUM_W-1:0], num_lo_q[15]};
  assign p_sat = quo_q[15] ? 16'h7FFF : quo_q;
  assign d_next = (ACC_W'(x) <<< 15) - s_q;
  assign r     = (58'(hp_q) <<< 20) + 58'(lp_q);
  assign w     = r + (58'sd1 <<< 29);
  assign gr    = w >>> 30;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rb_we) begin
      rb_mem[cmd_i.rb_waddr] <= value_i;
    end
    if (cmd_i.rd_en) begin
      rb_rd_q <= rb_mem[cmd_i.rb_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.st_we) begin
      st_mem[st_addr_i] <= p_sat;
    end
    if (cmd_i.rd_en) begin
      st_rd_q <= st_mem[st_addr_i];
    end
  end

  // arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.max_upd) begin
      if (cmd_i.max_first || x > max_q) begin
        max_q <= x;
      end
    end
    if (cmd_i.clr_acc) begin
      sum_q <= '0;
      s_q   <= '0;
    end
    if (cmd_i.exp_start) begin
      p1_q <= (2*EXP_W)'(exp_int(t[15:8])) * (2*EXP_W)'(exp_hi(t[7:4]));
      l_q  <= t[3:0];
    end
    if (cmd_i.exp_mid) begin
      p2_q <= (2*EXP_W)'(e1) * (2*EXP_W)'(exp_lo(l_q));
    end
    if (cmd_i.exp_fin) begin
      e_q <= e2;
    end
    if (cmd_i.sum_acc) begin
      sum_q <= sum_q + SUM_W'(e_q);
    end
    if (cmd_i.div_load) begin
      rem_q    <= (SUM_W + 1)'(num[SUM_W:16]);
      num_lo_q <= num[15:0];
      quo_q    <= '0;
    end
    if (cmd_i.div_step) begin
      num_lo_q <= {num_lo_q[14:0], 1'b0};
      if (sh >= {1'b0, sum_q}) begin
        rem_q <= sh - {1'b0, sum_q};
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= sh;
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (cmd_i.bs_mul) begin
      bprod_q <= x * $signed({1'b0, st_rd_q});
    end
    if (cmd_i.bs_acc) begin
      s_q <= s_q + ACC_W'(bprod_q);
    end
    if (cmd_i.bo_diff) begin
      d_q <= d_next;
      y_q <= st_rd_q;
    end
    if (cmd_i.bo_mul) begin
      hp_q <= $signed({1'b0, y_q}) * $signed(d_q[ACC_W-1:20]);
      lp_q <= $signed({1'b0, y_q}) * $signed({1'b0, d_q[19:0]});
    end
    if (cmd_i.bo_fin) begin
      if (gr > 58'sd32767) begin
        grad_q <= 16'h7FFF;
      end else if (gr < -58'sd32768) begin
        grad_q <= 16'h8000;
      end else begin
        grad_q <= gr[15:0];
      end
    end
  end

  // output register
  assign sts_o.out_free = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= cmd_i.emit_kind;
      last_q <= cmd_i.emit_last;
      ovf_q  <= cmd_i.emit_ovf;
      idx_q  <= cmd_i.row_idx;
      if (cmd_i.emit_zero) begin
        res_q <= '0;
      end else if (cmd_i.emit_kind == REQ_BWD) begin
        res_q <= grad_q;
      end else begin
        res_q <= p_sat;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign out_kind_o      = kind_q;
  assign out_row_index_o = idx_q;
  assign out_result_o    = res_q;
  assign out_last_o      = last_q;
  assign out_ovf_o       = ovf_q;

endmodule

`default_nettype wire

### src/sfb_ctrl.sv
// ----------------------------------------------------------------------------
// sfb_ctrl
// Controller: row collection, pass sequencing, row counter and config register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_ctrl import sfb_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  localparam int StAddrW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COL_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic               last_i,
  input  wire dp_sts_t            sts_i,
  output      dp_cmd_t            cmd_o,
  output      logic [StAddrW-1:0] st_addr_o
);

  localparam int RcW = $clog2(MAX_ROWS + 1);
  localparam logic [COL_W-1:0] LenCap = COL_W'((MAX_COLS < RB_DEPTH) ? MAX_COLS : RB_DEPTH);
  localparam logic [RcW-1:0] RowCap = RcW'(MAX_ROWS);

  typedef enum logic [10:0] {
    S_COLLECT = 11'b00000000001,
    S_RD      = 11'b00000000010,
    S_WAIT    = 11'b00000000100,
    S_E1      = 11'b00000001000,
    S_E2      = 11'b00000010000,
    S_E3      = 11'b00000100000,
    S_DIV     = 11'b00001000000,
    S_EMIT    = 11'b00010000000,
    S_BACC    = 11'b00100000000,
    S_BD1     = 11'b01000000000,
    S_BD2     = 11'b10000000000
  } state_e;

  typedef enum logic [5:0] {
    P_MAX  = 6'b000001,
    P_SUM  = 6'b000010,
    P_DIV  = 6'b000100,
    P_BSUM = 6'b001000,
    P_BOUT = 6'b010000,
    P_ZERO = 6'b100000
  } pass_e;

  state_e           state_q, state_d;
  pass_e            pass_q, pass_d;
  logic [COL_W-1:0] row_len_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] n_q, n_d;
  logic [COL_W-1:0] j_q, j_d;
  logic [3:0]       div_cnt_q, div_cnt_d;
  logic             kind_q, kind_d;
  logic             last_q, last_d;
  logic [RcW-1:0]   row_cnt_q;
  logic             row_done;

  logic             accept, complete, ovf, last_elem;
  logic [COL_W-1:0] len_min, eff_len, col_eff, col_inc;

  assign len_min   = (row_len_q == '0) ? COL_W'(1) : row_len_q;
  assign eff_len   = (len_min > LenCap) ? LenCap : len_min;
  assign accept    = in_valid_i && in_ready_o;
  assign col_eff   = (col_q != '0 && req_type_i != kind_q) ? '0 : col_q;
  assign col_inc   = col_eff + COL_W'(1);
  assign complete  = (col_inc >= eff_len) || last_i;
  assign ovf       = row_cnt_q >= RowCap;
  assign last_elem = (j_q + COL_W'(1)) == n_q;
  assign st_addr_o = StAddrW'(32'(row_cnt_q) * MAX_COLS + 32'(j_q));

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    col_d      = col_q;
    n_d        = n_q;
    j_d        = j_q;
    div_cnt_d  = div_cnt_q;
    kind_d     = kind_q;
    last_d     = last_q;
    row_done   = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rb_waddr  = col_eff[IDX_W-1:0];
    cmd_o.rb_raddr  = j_q[IDX_W-1:0];
    cmd_o.max_first = (j_q == '0);
    cmd_o.emit_kind = (pass_q == P_DIV) ? REQ_FWD : REQ_BWD;
    cmd_o.emit_last = last_elem;
    cmd_o.emit_ovf  = ovf;
    cmd_o.emit_zero = (pass_q == P_ZERO);
    cmd_o.row_idx   = IDX_W'(row_cnt_q);

    unique case (state_q)
      S_COLLECT: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.rb_we = 1'b1;
          kind_d      = req_type_i;
          if (complete) begin
            cmd_o.clr_acc = 1'b1;
            col_d  = '0;
            n_d    = col_inc;
            last_d = last_i;
            j_d    = '0;
            if (req_type_i == REQ_FWD) begin
              pass_d  = P_MAX;
              state_d = S_RD;
            end else if (ovf) begin
              pass_d  = P_ZERO;
              state_d = S_EMIT;
            end else begin
              pass_d  = P_BSUM;
              state_d = S_RD;
            end
          end else begin
            col_d = col_inc;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        unique case (pass_q) inside
          P_MAX: begin
            cmd_o.max_upd = 1'b1;
            state_d       = S_RD;
            if (last_elem) begin
              pass_d = P_SUM;
              j_d    = '0;
            end else begin
              j_d = j_q + COL_W'(1);
            end
          end
          P_SUM, P_DIV: begin
            cmd_o.exp_start = 1'b1;
            state_d         = S_E1;
          end
          P_BSUM: begin
            cmd_o.bs_mul = 1'b1;
            state_d      = S_BACC;
          end
          P_BOUT: begin
            cmd_o.bo_diff = 1'b1;
            state_d       = S_BD1;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_E1: begin
        cmd_o.exp_mid = 1'b1;
        state_d       = S_E2;
      end
      S_E2: begin
        cmd_o.exp_fin = 1'b1;
        state_d       = S_E3;
      end
      S_E3: begin
        if (pass_q == P_SUM) begin
          cmd_o.sum_acc = 1'b1;
          state_d       = S_RD;
          if (last_elem) begin
            pass_d = P_DIV;
            j_d    = '0;
          end else begin
            j_d = j_q + COL_W'(1);
          end
        end else begin
          cmd_o.div_load = 1'b1;
          div_cnt_d      = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 4'd1;
        if (div_cnt_q == 4'(DIV_STEPS - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_BACC: begin
        cmd_o.bs_acc = 1'b1;
        state_d      = S_RD;
        if (last_elem) begin
          pass_d = P_BOUT;
          j_d    = '0;
        end else begin
          j_d = j_q + COL_W'(1);
        end
      end
      S_BD1: begin
        cmd_o.bo_mul = 1'b1;
        state_d      = S_BD2;
      end
      S_BD2: begin
        cmd_o.bo_fin = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.st_we = (pass_q == P_DIV) && !ovf;
          if (last_elem) begin
            row_done = 1'b1;
            state_d  = S_COLLECT;
          end else begin
            j_d     = j_q + COL_W'(1);
            state_d = (pass_q == P_ZERO) ? S_EMIT : S_RD;
          end
        end
      end
      default: state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      pass_q    <= P_MAX;
      row_len_q <= ROW_LEN_RST;
      col_q     <= '0;
      n_q       <= COL_W'(1);
      j_q       <= '0;
      div_cnt_q <= '0;
      kind_q    <= REQ_FWD;
      last_q    <= 1'b0;
      row_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      col_q     <= col_d;
      n_q       <= n_d;
      j_q       <= j_d;
      div_cnt_q <= div_cnt_d;
      kind_q    <= kind_d;
      last_q    <= last_d;
      if (cfg_we_i) begin
        row_len_q <= cfg_data_i;
      end
      if (row_done) begin
        if (last_q) begin
          row_cnt_q <= '0;
        end else if (!ovf) begin
          row_cnt_q <= row_cnt_q + RcW'(1);
        end
      end
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result issued into occupied register");

  a_row_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && complete) |=> !in_ready_o) else $error("request taken while row busy");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COLLECT) |-> (j_q < n_q)) else $error("element index past row end");

  a_row_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= RowCap) else $error("row counter past capacity");

endmodule

`default_nettype wire

### src/softmax_forward_backward_unit.sv
// ----------------------------------------------------------------------------
// softmax_forward_backward_unit
// Row-wise fixed-point softmax with its gradient.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while a row is collected. A completed
// forward row is worked in three passes: the maximum, the exp sum and then
// each probability, set by the 16-step serial divider behind the
// three-stage exp table chain. A backward row is a dot product, then a split
// 16x40 multiply per gradient, or zero gradients for a row beyond the store.
// No request is taken while a row is being worked on. The output store needs
// no clearing after reset.
`default_nettype none

module softmax_forward_backward_unit import sfb_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [COL_W-1:0] cfg_data_i,
  sfb_in_if.sink                in_i,
  sfb_out_if.source             out_o
);

  localparam int StAddrW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [StAddrW-1:0] st_addr;
  logic               in_ready;

  assign in_i.ready = in_ready;

  sfb_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .req_type_i (in_i.req_type),
    .last_i     (in_i.last_of_tensor),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .st_addr_o  (st_addr)
  );

  sfb_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_addr_i       (st_addr),
    .value_i         (in_i.value),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_kind_o      (out_o.kind),
    .out_row_index_o (out_o.row_index),
    .out_result_o    (out_o.result),
    .out_last_o      (out_o.last_in_row),
    .out_ovf_o       (out_o.overflow)
  );

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Softmax forward/backward unit: rows of forward elements and backward error
// terms are sent over random row lengths, and every probability and gradient
// is compared with a predicted value worked out in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sfb_pkg::*;

  localparam int NCOLS = 64;
  localparam int NROWS = 64;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic        kind;
    logic [5:0]  row_index;
    logic [15:0] result;
    logic        last_in_row;
    logic        overflow;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [COL_W-1:0] cfg_data_i = '0;

  sfb_in_if  req_ch ();
  sfb_out_if res_ch ();

  softmax_forward_backward_unit #(.MAX_COLS(NCOLS), .MAX_ROWS(NROWS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_i(req_ch), .out_o(res_ch)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  int unsigned row_len_reg = 64;
  int          pend_vals[NCOLS];
  logic [15:0] prob_store[NROWS*NCOLS];
  bit          prob_written[NROWS*NCOLS];
  int unsigned pend_cols;
  int unsigned row_ctr;
  logic        pend_kind;

  result_t     expected_results[$];
  int          err_count;
  longint      cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  const int unsigned exp_i_tab[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                       22, 8, 3, 1};
  const int unsigned exp_h_tab[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                       42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                       27319, 25664};
  const int unsigned exp_l_tab[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                       63768, 63520, 63272, 63025, 62781, 62535, 62291,
                                       62048, 61806};

  function automatic int unsigned eff_len();
    int unsigned n;
    n = row_len_reg;
    if (n < 1) n = 1;
    if (n > NCOLS) n = NCOLS;
    return n;
  endfunction

  function automatic longint unsigned exp_fixed(int unsigned t);
    longint unsigned e;
    if ((t >> 8) >= 12) return 0;
    e = exp_i_tab[t >> 8];
    e = (e * exp_h_tab[(t >> 4) & 15] + 32768) >> 16;
    e = (e * exp_l_tab[t & 15] + 32768) >> 16;
    return e;
  endfunction

  function automatic longint floor_q30(longint v);
    longint w;
    w = v + (longint'(1) << 29);
    if (w >= 0) return w >>> 30;
    return -((-w + (longint'(1) << 30) - 1) >>> 30);
  endfunction

  task automatic predict_row(logic kind, logic [15:0] val, bit last);
    int unsigned n, base;
    bit ovf;
    longint unsigned e[NCOLS];
    longint unsigned total, p;
    longint s, g, y;
    int mx;
    result_t r;
    if (pend_cols > 0 && kind != pend_kind) pend_cols = 0;
    if (pend_cols >= NCOLS) pend_cols = 0;
    pend_kind = kind;
    pend_vals[pend_cols] = $signed(val);
    pend_cols++;
    if (pend_cols < eff_len() && !last) return;
    n = pend_cols;
    pend_cols = 0;
    ovf = row_ctr >= NROWS;
    base = ovf ? 0 : row_ctr * NCOLS;
    if (kind == REQ_FWD) begin
      mx = pend_vals[0];
      for (int j = 1; j < n; j++) if (pend_vals[j] > mx) mx = pend_vals[j];
      total = 0;
      for (int j = 0; j < n; j++) begin
        e[j] = exp_fixed(mx - pend_vals[j]);
        total = (total + e[j]) & 32'hffffffff;
      end
      for (int j = 0; j < n; j++) begin
        p = (e[j] * 32768 + (total >> 1)) / total;
        if (p > 32767) p = 32767;
        if (!ovf) begin
          prob_store[base + j] = p[15:0];
          prob_written[base + j] = 1'b1;
        end
        r = '{kind, row_ctr[5:0], p[15:0], j + 1 == n, ovf};
        expected_results.push_back(r);
      end
    end else begin
      s = 0;
      if (!ovf) for (int j = 0; j < n; j++) s += longint'(pend_vals[j]) * prob_store[base + j];
      for (int j = 0; j < n; j++) begin
        g = 0;
        if (!ovf) begin
          y = prob_store[base + j];
          g = floor_q30(y * (longint'(pend_vals[j]) * 32768 - s));
          if (g > 32767) g = 32767;
          if (g < -32768) g = -32768;
        end
        r = '{kind, row_ctr[5:0], g[15:0], j + 1 == n, ovf};
        expected_results.push_back(r);
      end
    end
    if (last) row_ctr = 0;
    else if (row_ctr < NROWS) row_ctr++;
  endtask

  task automatic send_request(logic kind, logic [15:0] val, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value <= val;
    req_ch.last_of_tensor <= last;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_row(kind, val, last);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_row_length(logic [COL_W-1:0] len);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    row_len_reg = len;
  endtask

  // backward rows only for stored rows of the current length or rows beyond the store
  function automatic bit row_stored(int unsigned n);
    if (row_ctr >= NROWS) return 1'b1;
    for (int j = 0; j < n; j++) if (!prob_written[row_ctr * NCOLS + j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(1023)) - 512);
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(4095));
    endcase
  endfunction

  task automatic send_row(logic kind, int unsigned n, bit last);
    for (int j = 0; j < n; j++) send_request(kind, rand_value(), last && (j + 1 == n));
  endtask

  task automatic test_directed();
    write_row_length(7'd4);
    send_request(REQ_FWD, 16'h7fff, 0);
    send_request(REQ_FWD, 16'h8000, 0);
    send_request(REQ_FWD, 16'h0000, 0);
    send_request(REQ_FWD, 16'hffff, 0);
    send_request(REQ_FWD, 16'h0100, 0);
    send_request(REQ_FWD, 16'h0100, 0);
    send_request(REQ_FWD, 16'h0100, 0);
    send_request(REQ_FWD, 16'h0a00, 1);
    // gradients of row 0, large errors for saturation
    send_request(REQ_FWD, 16'h0001, 0);
    send_request(REQ_BWD, 16'h7fff, 0);  // kind change drops the partial row
    send_request(REQ_BWD, 16'h8000, 0);
    send_request(REQ_BWD, 16'h5555, 1);  // early last
    send_row(REQ_FWD, 3, 1);
    send_row(REQ_BWD, 3, 1);
    write_row_length(7'd0);
    send_row(REQ_FWD, 2, 1);
    write_row_length(7'd127);
    send_row(REQ_FWD, 1, 1);
    send_row(REQ_BWD, 1, 1);
  endtask

  task automatic test_overflow();
    write_row_length(7'd1);
    for (int r = 0; r < NROWS + 2; r++) send_request(REQ_FWD, rand_value(), 0);
    send_request(REQ_BWD, rand_value(), 0);
    send_request(REQ_BWD, rand_value(), 1);
  endtask

  task automatic test_random(int rows);
    int unsigned n;
    for (int k = 0; k < rows; k++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: write_row_length(7'd64);
          1: write_row_length(7'd1);
          default: write_row_length(7'($urandom_range(2, 8)));
        endcase
      end
      n = eff_len();
      if ($urandom_range(7) == 0) begin
        send_request(REQ_FWD, rand_value(), 1'($urandom_range(1)));
        continue;
      end
      if (row_stored(n) && row_ctr > 0 && $urandom_range(2) == 0) begin
        send_row(REQ_BWD, n, $urandom_range(5) == 0);
      end else begin
        send_row(REQ_FWD, n, 0);
        if ($urandom_range(1)) begin
          // the row counter is left as it is; no tensor end is sent here
          row_ctr = row_ctr;
        end
      end
      if (k == rows / 2) wait_drained();
    end
  endtask

  // keep backward rows safe: end tensor, then rewrite forward before backward
  task automatic test_train(int rows);
    int unsigned n;
    if (pend_cols > 0 || row_ctr != 0) send_request(REQ_FWD, rand_value(), 1'b1);
    for (int k = 0; k < rows; k++) begin
      n = eff_len();
      send_row(REQ_FWD, n, 1);
      send_row(REQ_BWD, n, 1);
      if ($urandom_range(4) == 0) write_row_length(7'($urandom_range(1, 6)));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", res_ch.result);
          err_count++;
        end else begin
          result_t x;
          x = expected_results.pop_front();
          if (res_ch.kind !== x.kind) begin
            $error("kind exp %0d got %0d", x.kind, res_ch.kind); err_count++;
          end
          if (res_ch.row_index !== x.row_index) begin
            $error("row_index exp %0d got %0d", x.row_index, res_ch.row_index); err_count++;
          end
          if (res_ch.result !== x.result) begin
            $error("result exp %h got %h", x.result, res_ch.result); err_count++;
          end
          if (res_ch.last_in_row !== x.last_in_row) begin
            $error("last_in_row exp %0d got %0d", x.last_in_row, res_ch.last_in_row);
            err_count++;
          end
          if (res_ch.overflow !== x.overflow) begin
            $error("overflow exp %0d got %0d", x.overflow, res_ch.overflow); err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_FWD;
    req_ch.value = '0;
    req_ch.last_of_tensor = 1'b0;
    res_ch.ready = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 75;
    row_len_reg = ROW_LEN_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    write_row_length(7'd64);
    test_train(1);
    write_row_length(7'd3);
    test_train(5);
    send_idle_pct = 75;
    recv_idle_pct = 7;
    test_train(5);
    test_random(10);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_row_length(7'd4);
    test_train(5);
    test_random(6);
    wait_drained();
    repeat (2000) @(posedge clk_i);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
src/sfb_pkg.sv
src/sfb_in_if.sv
src/sfb_out_if.sv
src/sfb_dp.sv
src/sfb_ctrl.sv
src/softmax_forward_backward_unit.sv
test/tb.sv
